[rtl/core/bsm_pkg.sv]
package bsm_pkg;

  localparam int unsigned BANK_REG_COUNT = 8;
  localparam int unsigned BankIdxW = $clog2(BANK_REG_COUNT);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [2:0] OP_CPU_READ  = 3'd0;
  localparam logic [2:0] OP_CPU_WRITE = 3'd1;
  localparam logic [2:0] OP_PPU_READ  = 3'd2;
  localparam logic [2:0] OP_PPU_WRITE = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM = 3'd2;
  localparam logic [2:0] TGT_CHR     = 3'd3;
  localparam logic [2:0] TGT_NT      = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_COUNT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUAD_NT           = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_MIRRORING = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHR_IS_RAM        = 2'd3;

  localparam logic [6:0] PRG_BANK_COUNT_RESET = 7'd32;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic        write_allowed;
    logic        irq_line;
  } out_item_t;

  typedef struct packed {
    logic [6:0] prg_bank_count;
    logic       quad_nt;
    logic       chr_is_ram;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                          bank_select;
    logic [BANK_REG_COUNT-1:0][7:0]      bank_regs;
    logic                                mirror_horizontal;
    logic [1:0]                          ram_control;
    logic [7:0]                          scan_latch;
    logic [7:0]                          scan_count;
    logic                                scan_reload;
    logic                                scan_enable;
    logic                                irq_pending;
  } map_state_t;

endpackage

[rtl/core/bank_switch_mapper_scanline_irq.sv]
// Bank-switching cartridge mapper with a scanline interrupt counter.
// Input channel (in_valid_i / in_stall_o / in_item_i): one CPU read or write,
// PPU read or write, or scanline tick per item. Output channel (out_valid_o /
// out_stall_i / out_item_o): exactly one result per item, in order: target
// memory, translated address, write permission and the interrupt line.
// Configuration: cfg_we_i with cfg_index_i and cfg_data_i writes one register
// (index 2, initial mirroring, is ignored); write only while no item is in flight.
// An accepted item is registered in the input register, then decoded against
// the mapper state into the result register once that register can advance,
// and its result is offered from there until the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single decode stage between the input and result registers; mapper
// state updates in that same stage.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; the input stalls only while both are full.
// Reset empties both registers, clears the bank, mirroring, RAM and interrupt
// state, and returns the configuration to 32 PRG banks, mirrored nametables
// and CHR ROM.
module bank_switch_mapper_scanline_irq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bsm_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bsm_pkg::out_item_t              out_item_o,
  input  logic                            cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bsm_pkg::CfgDataW-1:0]    cfg_data_i
);
  import bsm_pkg::*;

  in_item_t   item_q;
  logic       item_valid_q;
  out_item_t  res_q;
  out_item_t  res_d;
  logic       res_valid_q;
  map_state_t state_q;
  map_state_t state_d;
  cfg_t       cfg_q;
  logic       advance;

  assign advance    = !res_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !advance;

  bsm_core u_core (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_q       <= '0;
      state_q     <= '0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
      if (item_valid_q) begin
        res_q   <= res_d;
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_bank_count <= PRG_BANK_COUNT_RESET;
      cfg_q.quad_nt        <= 1'b0;
      cfg_q.chr_is_ram     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRG_BANK_COUNT: cfg_q.prg_bank_count <= cfg_data_i;
        CFG_QUAD_NT:        cfg_q.quad_nt        <= cfg_data_i[0];
        CFG_CHR_IS_RAM:     cfg_q.chr_is_ram     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

[rtl/core/bsm_core.sv]
module bsm_core (
  input  bsm_pkg::in_item_t   item_i,
  input  bsm_pkg::cfg_t       cfg_i,
  input  bsm_pkg::map_state_t state_i,
  output bsm_pkg::map_state_t state_o,
  output bsm_pkg::out_item_t  result_o
);
  import bsm_pkg::*;

  logic [15:0] addr;
  logic [13:0] ppu_addr;
  logic [12:0] chr_addr;
  logic [5:0]  top_bank;
  logic [5:0]  second_bank;
  logic [5:0]  prg_bank;
  logic [18:0] prg_addr;
  logic [18:0] chr_mapped;
  logic [18:0] nt_mapped;
  logic [7:0]  cnt_next;

  assign addr        = item_i.bus_address;
  assign ppu_addr    = addr[13:0];
  assign chr_addr    = {ppu_addr[12] ^ state_i.bank_select[7], ppu_addr[11:0]};
  assign top_bank    = cfg_i.prg_bank_count[5:0] - 6'd1;
  assign second_bank = cfg_i.prg_bank_count[5:0] - 6'd2;

  always_comb begin
    case (addr[14:13])
      2'd0:    prg_bank = state_i.bank_select[6] ? second_bank : state_i.bank_regs[6][5:0];
      2'd1:    prg_bank = state_i.bank_regs[7][5:0];
      2'd2:    prg_bank = state_i.bank_select[6] ? state_i.bank_regs[6][5:0] : second_bank;
      default: prg_bank = top_bank;
    endcase
  end

  assign prg_addr = {prg_bank, addr[12:0]};

  always_comb begin
    case (chr_addr[12:10])
      3'd0, 3'd1: chr_mapped = {1'b0, state_i.bank_regs[0][7:1], chr_addr[10:0]};
      3'd2, 3'd3: chr_mapped = {1'b0, state_i.bank_regs[1][7:1], chr_addr[10:0]};
      3'd4:       chr_mapped = {1'b0, state_i.bank_regs[2], chr_addr[9:0]};
      3'd5:       chr_mapped = {1'b0, state_i.bank_regs[3], chr_addr[9:0]};
      3'd6:       chr_mapped = {1'b0, state_i.bank_regs[4], chr_addr[9:0]};
      default:    chr_mapped = {1'b0, state_i.bank_regs[5], chr_addr[9:0]};
    endcase
  end

  always_comb begin
    if (cfg_i.quad_nt) begin
      nt_mapped = {7'd0, ppu_addr[11:0]};
    end else if (state_i.mirror_horizontal) begin
      nt_mapped = {8'd0, ppu_addr[11], ppu_addr[9:0]};
    end else begin
      nt_mapped = {8'd0, ppu_addr[10:0]};
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    cnt_next = state_i.scan_count;
    case (item_i.operation)
      OP_CPU_READ, OP_CPU_WRITE: begin
        if (addr[15:13] == 3'b011) begin
          if (state_i.ram_control[1]) begin
            result_o.target         = TGT_PRG_RAM;
            result_o.mapped_address = {6'd0, addr[12:0]};
            result_o.write_allowed  = (item_i.operation == OP_CPU_WRITE) &&
                                      !state_i.ram_control[0];
          end
        end else if (addr[15]) begin
          if (item_i.operation == OP_CPU_WRITE) begin
            case (addr[14:13])
              2'd0: begin
                if (!addr[0]) begin
                  state_o.bank_select = item_i.write_data;
                end else begin
                  for (int i = 0; i < BANK_REG_COUNT; i++) begin
                    if (state_i.bank_select[BankIdxW-1:0] == BankIdxW'(i)) begin
                      state_o.bank_regs[i] = item_i.write_data;
                    end
                  end
                end
              end
              2'd1: begin
                if (!addr[0]) begin
                  if (!cfg_i.quad_nt) begin
                    state_o.mirror_horizontal = item_i.write_data[0];
                  end
                end else begin
                  state_o.ram_control = item_i.write_data[7:6];
                end
              end
              2'd2: begin
                if (!addr[0]) begin
                  state_o.scan_latch = item_i.write_data;
                end else begin
                  state_o.scan_reload = 1'b1;
                end
              end
              default: begin
                if (!addr[0]) begin
                  state_o.scan_enable = 1'b0;
                  state_o.irq_pending = 1'b0;
                end else begin
                  state_o.scan_enable = 1'b1;
                end
              end
            endcase
          end else begin
            result_o.target         = TGT_PRG_ROM;
            result_o.mapped_address = prg_addr;
          end
        end
      end
      OP_PPU_READ, OP_PPU_WRITE: begin
        if (!ppu_addr[13]) begin
          result_o.target         = TGT_CHR;
          result_o.mapped_address = chr_mapped;
          result_o.write_allowed  = (item_i.operation == OP_PPU_WRITE) && cfg_i.chr_is_ram;
        end else if (ppu_addr[13:8] != 6'h3f) begin
          result_o.target         = TGT_NT;
          result_o.mapped_address = nt_mapped;
          result_o.write_allowed  = (item_i.operation == OP_PPU_WRITE);
        end
      end
      OP_TICK: begin
        if ((state_i.scan_count == 8'd0) || state_i.scan_reload) begin
          cnt_next            = state_i.scan_latch;
          state_o.scan_reload = 1'b0;
        end else begin
          cnt_next = state_i.scan_count - 8'd1;
        end
        state_o.scan_count = cnt_next;
        if ((cnt_next == 8'd0) && state_i.scan_enable) begin
          state_o.irq_pending = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result_o.irq_line = state_o.irq_pending;
  end

endmodule

[rtl/core/bsm_checker.sv]
module bsm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bsm_pkg::out_item_t              out_item_o
);
  import bsm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result side can move");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.target == TGT_NONE) |-> out_item_o.mapped_address == 19'd0)
    else $error("no target but nonzero address");

  a_wr_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_allowed |->
      (out_item_o.target == TGT_PRG_RAM) || (out_item_o.target == TGT_CHR) ||
      (out_item_o.target == TGT_NT))
    else $error("write allowed to a read-only or absent target");

  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.target == TGT_PRG_RAM) |->
      out_item_o.mapped_address[18:13] == 6'd0)
    else $error("PRG RAM address out of range");

endmodule

bind bank_switch_mapper_scanline_irq bsm_checker u_bsm_checker (.*);

[tb/bank_switch_mapper_scanline_irq_tb.sv]
`timescale 1ns / 100ps

module bank_switch_mapper_scanline_irq_tb;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  // Mapper configuration and state as the block should hold them
  logic [6:0] c_prg_banks;
  logic c_quad_nt;
  logic c_chr_ram;
  logic [7:0] m_sel;
  logic [7:0] m_bank [BANK_REG_COUNT];
  logic m_mir_h;
  logic [1:0] m_ram_ctl;
  logic [7:0] m_latch;
  logic [7:0] m_count;
  logic m_reload;
  logic m_irq_en;
  logic m_irq_pend;

  out_item_t decode_q [$];
  out_item_t want;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  bit hold_req = 1'b0;

  bank_switch_mapper_scanline_irq u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bank_switch_mapper_scanline_irq_tb: errors");
      $finish;
    end
  end

  function automatic out_item_t decode_access(input in_item_t it);
    out_item_t r;
    logic [15:0] a;
    logic [13:0] pa;
    logic [12:0] ca;
    logic [7:0] d;
    logic [5:0] bank;
    logic [5:0] last;
    logic [5:0] second;
    r = '0;
    a = it.bus_address;
    d = it.write_data;
    pa = a[13:0];
    last = c_prg_banks[5:0] - 6'd1;
    second = c_prg_banks[5:0] - 6'd2;
    case (it.operation)
      OP_CPU_READ, OP_CPU_WRITE: begin
        if (a[15:13] == 3'b011) begin
          if (m_ram_ctl[1]) begin
            r.target = TGT_PRG_RAM;
            r.mapped_address = {6'd0, a[12:0]};
            r.write_allowed = (it.operation == OP_CPU_WRITE) && !m_ram_ctl[0];
          end
        end else if (a[15]) begin
          if (it.operation == OP_CPU_WRITE) begin
            case (a[14:13])
              2'd0: begin
                if (!a[0]) m_sel = d;
                else m_bank[m_sel[2:0]] = d;
              end
              2'd1: begin
                if (a[0]) m_ram_ctl = d[7:6];
                else if (!c_quad_nt) m_mir_h = d[0];
              end
              2'd2: begin
                if (!a[0]) m_latch = d;
                else m_reload = 1'b1;
              end
              default: begin
                if (a[0]) begin
                  m_irq_en = 1'b1;
                end else begin
                  m_irq_en = 1'b0;
                  m_irq_pend = 1'b0;
                end
              end
            endcase
          end else begin
            case (a[14:13])
              2'd0: bank = m_sel[6] ? second : m_bank[6][5:0];
              2'd1: bank = m_bank[7][5:0];
              2'd2: bank = m_sel[6] ? m_bank[6][5:0] : second;
              default: bank = last;
            endcase
            r.target = TGT_PRG_ROM;
            r.mapped_address = {bank, a[12:0]};
          end
        end
      end
      OP_PPU_READ, OP_PPU_WRITE: begin
        if (!pa[13]) begin
          ca = pa[12:0] ^ {m_sel[7], 12'd0};
          r.target = TGT_CHR;
          if (!ca[12]) r.mapped_address = {1'b0, m_bank[{2'b00, ca[11]}][7:1], ca[10:0]};
          else r.mapped_address = {1'b0, m_bank[3'(ca[11:10]) + 3'd2], ca[9:0]};
          r.write_allowed = (it.operation == OP_PPU_WRITE) && c_chr_ram;
        end else if (pa <= 14'h3eff) begin
          r.target = TGT_NT;
          if (c_quad_nt) r.mapped_address = {7'd0, pa[11:0]};
          else if (m_mir_h) r.mapped_address = {8'd0, pa[11], pa[9:0]};
          else r.mapped_address = {8'd0, pa[10:0]};
          r.write_allowed = (it.operation == OP_PPU_WRITE);
        end
      end
      OP_TICK: begin
        if (m_count == 8'd0 || m_reload) begin
          m_count = m_latch;
          m_reload = 1'b0;
        end else begin
          m_count = m_count - 8'd1;
        end
        if (m_count == 8'd0 && m_irq_en) m_irq_pend = 1'b1;
      end
      default: ;
    endcase
    r.irq_line = m_irq_pend;
    return r;
  endfunction

  function automatic logic [15:0] reg_addr(input logic [1:0] slot, input bit odd);
    return {1'b1, slot, 12'($urandom()), odd};
  endfunction

  function automatic in_item_t rand_access();
    in_item_t it;
    it.operation = OP_CPU_READ;
    it.bus_address = 16'($urandom());
    it.write_data = 8'($urandom());
    case ($urandom_range(0, 19))
      0, 1, 2: it.bus_address[15] = 1'b1;
      3, 4: begin
        it.operation = $urandom_range(0, 1) ? OP_CPU_WRITE : OP_CPU_READ;
        it.bus_address[15:13] = 3'b011;
      end
      5: it.operation = $urandom_range(0, 1) ? OP_CPU_WRITE : OP_CPU_READ;
      6, 7, 8, 9: begin
        it.operation = OP_CPU_WRITE;
        it.bus_address[15] = 1'b1;
        if (it.bus_address[14:13] == 2'd2 && $urandom_range(0, 1))
          it.write_data = 8'($urandom_range(0, 6));
      end
      10, 11, 12: it.operation = OP_PPU_READ;
      13, 14: it.operation = OP_PPU_WRITE;
      15: begin
        it.operation = $urandom_range(0, 1) ? OP_PPU_WRITE : OP_PPU_READ;
        it.bus_address[13] = 1'b1;
      end
      16, 17, 18: it.operation = OP_TICK;
      default: it.operation = 3'($urandom_range(5, 7));
    endcase
    return it;
  endfunction

  task automatic send_access(input in_item_t it);
    int gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    decode_q.push_back(decode_access(it));
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [15:0] addr,
                         input logic [7:0] data);
    in_item_t it;
    it.operation = op;
    it.bus_address = addr;
    it.write_data = data;
    send_access(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_PRG_BANK_COUNT: c_prg_banks = val;
      CFG_QUAD_NT: c_quad_nt = val[0];
      CFG_INITIAL_MIRRORING: ;
      default: c_chr_ram = val[0];
    endcase
  endtask

  task automatic apply_config(input logic [6:0] cnt, input bit four, input bit mir,
                              input bit chr);
    wait_idle();
    write_reg(CFG_PRG_BANK_COUNT, cnt);
    write_reg(CFG_QUAD_NT, {6'($urandom()), four});
    write_reg(CFG_INITIAL_MIRRORING, {6'($urandom()), mir});
    write_reg(CFG_CHR_IS_RAM, {6'($urandom()), chr});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_decode_extremes();
    send_op(OP_CPU_READ, 16'h0000, 8'h00);
    send_op(OP_CPU_WRITE, 16'h5fff, 8'hff);
    send_op(OP_CPU_READ, 16'h6000, 8'h00);
    send_op(OP_CPU_READ, 16'h8000, 8'h00);
    send_op(OP_CPU_READ, 16'hffff, 8'h00);
    send_op(OP_PPU_WRITE, 16'h1fff, 8'h55);
    send_op(OP_PPU_READ, 16'h2000, 8'h00);
    send_op(OP_PPU_WRITE, 16'h3eff, 8'haa);
    send_op(OP_PPU_READ, 16'h3f00, 8'h00);
    send_op(OP_PPU_READ, 16'hffff, 8'h00);
    send_op(3'd7, 16'hffff, 8'hff);
    send_op(OP_TICK, 16'h0000, 8'h00);
    wait_idle();
  endtask

  task automatic test_register_effects();
    send_op(OP_CPU_WRITE, 16'h8000, 8'h46);
    send_op(OP_CPU_WRITE, 16'h8001, 8'hff);
    send_op(OP_CPU_READ, 16'h8000, 8'h00);
    send_op(OP_CPU_WRITE, 16'h8000, 8'h82);
    send_op(OP_PPU_READ, 16'h0000, 8'h00);
    send_op(OP_CPU_WRITE, 16'ha001, 8'h80);
    send_op(OP_CPU_WRITE, 16'h7fff, 8'h12);
    send_op(OP_CPU_WRITE, 16'ha000, 8'h01);
    send_op(OP_PPU_READ, 16'h2c00, 8'h00);
    send_op(OP_CPU_WRITE, 16'he001, 8'h00);
    send_op(OP_TICK, 16'h0000, 8'h00);
    send_op(OP_CPU_WRITE, 16'he000, 8'h00);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    int i;
    logic [6:0] cnt;
    for (i = 0; i < 8; i++) begin
      case (i)
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd2;
        3: cnt = 7'd64;
        4: cnt = 7'd127;
        default: cnt = 7'($urandom_range(2, 64));
      endcase
      apply_config(cnt, i[0], 1'($urandom_range(0, 1)), i[1]);
      sender_gaps = (i != 2);
      repeat (50) send_access(rand_access());
    end
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_irq_sequences();
    int n;
    logic [7:0] latch;
    repeat (6) begin
      latch = 8'($urandom_range(0, 9));
      send_op(OP_CPU_WRITE, reg_addr(2'd2, 1'b0), latch);
      send_op(OP_CPU_WRITE, reg_addr(2'd2, 1'b1), 8'($urandom()));
      send_op(OP_CPU_WRITE, reg_addr(2'd3, $urandom_range(0, 4) != 0), 8'($urandom()));
      n = $urandom_range(1, 2 * latch + 3);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_access(rand_access());
        if ($urandom_range(0, 11) == 0) begin
          send_op(OP_CPU_WRITE, reg_addr(2'd3, 1'b0), 8'($urandom()));
          send_op(OP_CPU_WRITE, reg_addr(2'd3, 1'b1), 8'($urandom()));
        end
        send_op(OP_TICK, 16'($urandom()), 8'($urandom()));
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_access(rand_access());
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_mix();
    repeat (2) begin
      apply_config(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat (75) send_access(rand_access());
    end
    wait_idle();
  endtask

  initial begin : rx_pattern
    int seg;
    int pct;
    out_stall <= 1'b0;
    forever begin
      seg = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          out_stall <= 1'b0;
        end else begin
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decode_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = decode_q.pop_front();
        if (out_item.target !== want.target ||
            out_item.mapped_address !== want.mapped_address ||
            out_item.write_allowed !== want.write_allowed ||
            out_item.irq_line !== want.irq_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: target %0d/%0d addr %h/%h wr %b/%b irq %b/%b (exp/got)",
                     want.target, out_item.target, want.mapped_address,
                     out_item.mapped_address, want.write_allowed, out_item.write_allowed,
                     want.irq_line, out_item.irq_line);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    c_prg_banks = PRG_BANK_COUNT_RESET;
    c_quad_nt = 1'b0;
    c_chr_ram = 1'b0;
    m_sel = '0;
    foreach (m_bank[i]) m_bank[i] = '0;
    m_mir_h = 1'b0;
    m_ram_ctl = '0;
    m_latch = '0;
    m_count = '0;
    m_reload = 1'b0;
    m_irq_en = 1'b0;
    m_irq_pend = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_decode_extremes();
    test_register_effects();
    test_config_sweep();
    test_irq_sequences();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decode_q.size() == 0) begin
      $display("bank_switch_mapper_scanline_irq_tb: clean");
    end else begin
      $display("bank_switch_mapper_scanline_irq_tb: errors");
    end
    $finish;
  end

endmodule
